/* design/soa_pkg.sv */
// ----------------------------------------------------------------------------
// soa_pkg
// Shared constants for the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;
    localparam int         MAX_SLABS      = 16;
    localparam int         MAX_OBJECTS    = 32;
    localparam logic       OP_ALLOC       = 1'b0;
    localparam logic       OP_RELEASE     = 1'b1;
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_SLAB     = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC   = 2'd2;
    localparam logic [1:0] TAG_NONE       = 2'd0;
    localparam logic [1:0] TAG_EMPTY      = 2'd1;
    localparam logic [1:0] TAG_PARTIAL    = 2'd2;
    localparam logic [1:0] TAG_FULL       = 2'd3;
    localparam logic       REG_OBJ_IN_USE = 1'b0;
    localparam logic       REG_SLAB_LIMIT = 1'b1;
endpackage

/* design/slab_object_allocator_top.sv */
// Sequence: a release or an exhaustion goes S_DEC, S_FIN; an allocate from a listed slab
//   goes S_DEC, S_RD, S_FIN; one that creates a slab pushes its n objects in S_FILL between
//   S_DEC and S_RD (n = objects per slab). One request at a time: the next word is taken
//   the cycle after the result word leaves.
// Reset: synchronous active low; clears slab bookkeeping, list heads and counters.
//   The free-stack RAM is filled on slab creation and needs no clearing pass.
// ----------------------------------------------------------------------------
// slab_object_allocator_top
// Allocates and releases objects from slabs tracked on partial/empty lists.
// ----------------------------------------------------------------------------
module slab_object_allocator_top
    import soa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // op[0], slab_in[4:1], object_in[9:5]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // status[1:0], slab_out[5:2], object_out[10:6],
                                       // first_use[11]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);
    localparam int SW  = $clog2(MAX_SLABS) > 0 ? $clog2(MAX_SLABS) : 1;
    localparam int OW  = $clog2(MAX_OBJECTS) > 0 ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW  = $clog2(MAX_OBJECTS + 1);
    localparam int NW  = $clog2(MAX_SLABS + 1);
    localparam int AW  = $clog2(MAX_SLABS * MAX_OBJECTS) > 0 ?
                         $clog2(MAX_SLABS * MAX_OBJECTS) : 1;
    localparam logic [NW-1:0] NIL = NW'(MAX_SLABS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEC  = 5'b00010,
        S_FILL = 5'b00100,
        S_RD   = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    // ------------------------------------------------------------------
    // small per-slab state in flip-flops (at most MAX_SLABS entries)
    // ------------------------------------------------------------------
    logic [MAX_OBJECTS-1:0] r_alloc   [MAX_SLABS];
    logic [MAX_OBJECTS-1:0] r_created [MAX_SLABS];
    logic [CW-1:0]          r_use     [MAX_SLABS];
    logic [CW-1:0]          r_depth   [MAX_SLABS];
    logic [NW-1:0]          r_next    [MAX_SLABS];
    logic [NW-1:0]          r_prev    [MAX_SLABS];
    logic [1:0]             r_tag     [MAX_SLABS];
    logic [NW-1:0]          r_phead, r_ehead, r_made;
    logic [5:0]             r_oiu;
    logic [4:0]             r_lim;

    t_state        r_state;
    logic          r_op;
    logic [SW-1:0] r_slab;
    logic [3:0]    r_sin;
    logic [4:0]    r_oin;
    logic [CW-1:0] r_fill_cnt, r_fill_n;
    logic          r_out_v;
    logic [1:0]    r_st;
    logic [3:0]    r_so;
    logic [4:0]    r_oo;
    logic          r_fu;

    // free stack memory
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [OW-1:0] w_wdata, w_rdata;

    soa_ram #(.WIDTH(OW), .DEPTH(MAX_SLABS * MAX_OBJECTS)) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s, input logic [CW-1:0] d);
        logic [AW+CW-1:0] a;
        a = (AW+CW)'(s) * (AW+CW)'(MAX_OBJECTS) + (AW+CW)'(d);
        return a[AW-1:0];
    endfunction

    logic [NW-1:0] w_limc;
    logic [CW-1:0] w_nobj;
    assign w_limc = (r_lim > 5'(MAX_SLABS)) ? NIL : NW'(r_lim);
    always_comb begin
        if (r_oiu == 6'd0) begin
            w_nobj = CW'(1);
        end else if (32'(r_oiu) > MAX_OBJECTS) begin
            w_nobj = CW'(MAX_OBJECTS);
        end else begin
            w_nobj = CW'(r_oiu);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_v;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {4'd0, r_fu, r_oo, r_so, r_st};

    // stack write/read address selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = addr_of(r_slab, r_fill_cnt);
        w_wdata = r_fill_cnt[OW-1:0];
        w_raddr = addr_of(r_slab, r_depth[r_slab] - CW'(1));
        if (r_state == S_FILL) begin
            w_we = 1'b1;
        end else if (r_state == S_FIN && r_op == OP_RELEASE && r_st == ST_OK) begin
            // push the released object on its slab's stack
            w_we    = 1'b1;
            w_waddr = addr_of(SW'(r_sin), r_depth[SW'(r_sin)]);
            w_wdata = r_oin[OW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // sequencer and bookkeeping
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        logic [1:0]    ntag;
        logic [CW-1:0] nd, nu;
        logic [OW-1:0] o;
        logic [NW-1:0] p, n, h;
        logic [SW-1:0] s;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_phead <= NIL;
            r_ehead <= NIL;
            r_made  <= '0;
            r_oiu   <= 6'd32;
            r_lim   <= 5'd16;
            for (int i = 0; i < MAX_SLABS; i++) begin
                r_alloc[i]   <= '0;
                r_created[i] <= '0;
                r_use[i]     <= '0;
                r_depth[i]   <= '0;
                r_tag[i]     <= TAG_NONE;
            end
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            // configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_OBJ_IN_USE: r_oiu <= i_cfg_data;
                    REG_SLAB_LIMIT: r_lim <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op    <= s_axis_tdata[0];
                        r_sin   <= s_axis_tdata[4:1];
                        r_oin   <= s_axis_tdata[9:5];
                        r_st    <= ST_OK;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_state <= S_FIN;
                    if (r_op == OP_RELEASE) begin
                        r_so <= r_sin;
                        r_oo <= r_oin;
                        r_fu <= 1'b0;
                        r_st <= (NW'(r_sin) < r_made && 32'(r_sin) < MAX_SLABS &&
                                 32'(r_oin) < MAX_OBJECTS &&
                                 r_alloc[SW'(r_sin)][OW'(r_oin)]) ? ST_OK : ST_NOT_ALLOC;
                    end else if (r_phead != NIL) begin
                        r_slab  <= r_phead[SW-1:0];
                        r_state <= S_RD;
                    end else if (r_ehead != NIL) begin
                        r_slab  <= r_ehead[SW-1:0];
                        r_state <= S_RD;
                    end else if (r_made < w_limc) begin
                        r_slab     <= r_made[SW-1:0];
                        r_fill_cnt <= '0;
                        r_fill_n   <= w_nobj;
                        r_made     <= r_made + NW'(1);
                        r_state    <= S_FILL;
                    end else begin
                        r_st <= ST_NO_SLAB;
                        r_so <= '0;
                        r_oo <= '0;
                        r_fu <= 1'b0;
                    end
                end
                S_FILL: begin
                    // push objects 0..n-1
                    r_fill_cnt <= r_fill_cnt + CW'(1);
                    if (r_fill_cnt + CW'(1) == r_fill_n) begin
                        r_depth[r_slab] <= r_fill_n;
                        r_use[r_slab]   <= '0;
                        r_tag[r_slab]   <= TAG_NONE;
                        r_state         <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_FIN;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // finish: apply the stack result and relink the slab
            if (r_state == S_FIN && !(r_op == OP_RELEASE && r_st != ST_OK) &&
                !(r_op == OP_ALLOC && r_st == ST_NO_SLAB)) begin
                s = (r_op == OP_RELEASE) ? SW'(r_sin) : r_slab;
                if (r_op == OP_RELEASE) begin
                    nd = r_depth[s] + CW'(1);
                    nu = (r_use[s] != '0) ? r_use[s] - CW'(1) : '0;
                    r_alloc[s][OW'(r_oin)] <= 1'b0;
                end else begin
                    o  = (32'(w_rdata) >= MAX_OBJECTS) ? '0 : w_rdata;
                    nd = r_depth[s] - CW'(1);
                    nu = r_use[s] + CW'(1);
                    r_fu <= !r_created[s][o];
                    r_created[s][o] <= 1'b1;
                    r_alloc[s][o]   <= 1'b1;
                    r_st <= ST_OK;
                    r_so <= 4'(s);
                    r_oo <= 5'(o);
                end
                r_depth[s] <= nd;
                r_use[s]   <= nu;
                ntag = (nd == '0) ? TAG_FULL : (nu == '0) ? TAG_EMPTY : TAG_PARTIAL;
                if (r_tag[s] != ntag) begin
                    r_tag[s] <= ntag;
                    // unlink from old list
                    p = r_prev[s];
                    n = r_next[s];
                    h = (ntag == TAG_PARTIAL) ? r_phead : r_ehead;
                    if (r_tag[s] == TAG_PARTIAL || r_tag[s] == TAG_EMPTY) begin
                        if (p != NIL) begin
                            r_next[p[SW-1:0]] <= n;
                        end else if (r_tag[s] == TAG_PARTIAL) begin
                            r_phead <= n;
                        end else begin
                            r_ehead <= n;
                        end
                        if (n != NIL) begin
                            r_prev[n[SW-1:0]] <= p;
                        end
                        if (h == NW'(s)) begin
                            h = n;
                        end
                    end
                    r_next[s] <= (ntag != TAG_FULL) ? h : NIL;
                    r_prev[s] <= NIL;
                    // push on new list head
                    if (ntag != TAG_FULL) begin
                        if (h != NIL) begin
                            r_prev[h[SW-1:0]] <= NW'(s);
                        end
                        if (ntag == TAG_PARTIAL) begin
                            r_phead <= NW'(s);
                        end else begin
                            r_ehead <= NW'(s);
                        end
                    end
                end
            end
            if (r_state == S_FIN) begin
                r_out_v <= 1'b1;
            end
        end
    end
endmodule

/* design/soa_ram.sv */
// ----------------------------------------------------------------------------
// soa_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module soa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* test/slab_object_allocator_checker.sv */
// ----------------------------------------------------------------------------
// slab_object_allocator_checker
// Watches the request, result and register channels of the slab allocator,
// tracks slab lists and free stacks on its own, and compares every result
// word with the oldest predicted one.
// ----------------------------------------------------------------------------
module slab_object_allocator_checker
    import soa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [15:0] i_req_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [15:0] i_rsp_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int NSLAB = 16;
    localparam int NOBJ  = 32;
    localparam int NIL   = NSLAB;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slab;
        logic [4:0] obj;
        logic       first;
    } grant_t;

    logic [5:0]  cap_reg;
    logic [4:0]  limit_reg;
    logic [4:0]  free_stk [NSLAB][NOBJ];
    int          free_top [NSLAB];
    logic [31:0] held_map [NSLAB];
    logic [31:0] seen_map [NSLAB];
    int          live_cnt [NSLAB];
    int          link_nxt [NSLAB];
    int          link_prv [NSLAB];
    logic [1:0]  slab_tag [NSLAB];
    int          partial_hd;
    int          empty_hd;
    int          slabs_built;
    grant_t      grant_q[$];

    // Take a slab off whichever free list holds it
    task automatic detach_slab(input int s);
        int p;
        int n;
        p = link_prv[s];
        n = link_nxt[s];
        if (slab_tag[s] == TAG_PARTIAL || slab_tag[s] == TAG_EMPTY) begin
            if (p < NIL) link_nxt[p] = n;
            else if (slab_tag[s] == TAG_PARTIAL) partial_hd = n;
            else empty_hd = n;
            if (n < NIL) link_prv[n] = p;
        end
        slab_tag[s] = TAG_NONE;
        link_nxt[s] = NIL;
        link_prv[s] = NIL;
    endtask

    // File a slab on the list that matches its fill level
    task automatic file_slab(input int s);
        logic [1:0] t;
        int hd;
        if (free_top[s] == 0) t = TAG_FULL;
        else if (live_cnt[s] == 0) t = TAG_EMPTY;
        else t = TAG_PARTIAL;
        if (slab_tag[s] != t) begin
            detach_slab(s);
            slab_tag[s] = t;
            if (t != TAG_FULL) begin
                hd = (t == TAG_PARTIAL) ? partial_hd : empty_hd;
                link_prv[s] = NIL;
                link_nxt[s] = hd;
                if (hd < NIL) link_prv[hd] = s;
                if (t == TAG_PARTIAL) partial_hd = s;
                else empty_hd = s;
            end
        end
    endtask

    // Compute the result word of one request and update the slab state
    task automatic serve_request(input logic [15:0] w);
        grant_t g;
        logic       op;
        int         sl;
        int         ob;
        int         s;
        int         n;
        int         lim;
        op = w[0];
        sl = int'(w[4:1]);
        ob = int'(w[9:5]);
        g  = '0;
        if (op == OP_RELEASE) begin
            g.slab = 4'(sl);
            g.obj  = 5'(ob);
            if (sl >= slabs_built || !held_map[sl][ob]) begin
                g.status = ST_NOT_ALLOC;
            end else begin
                g.status = ST_OK;
                held_map[sl][ob] = 1'b0;
                if (free_top[sl] < NOBJ) begin
                    free_stk[sl][free_top[sl]] = 5'(ob);
                    free_top[sl]++;
                end
                if (live_cnt[sl] > 0) live_cnt[sl]--;
                file_slab(sl);
            end
        end else begin
            s   = NIL;
            lim = (int'(limit_reg) > NSLAB) ? NSLAB : int'(limit_reg);
            if (partial_hd < NIL) begin
                s = partial_hd;
            end else if (empty_hd < NIL) begin
                s = empty_hd;
            end else if (slabs_built < lim) begin
                n = int'(cap_reg);
                if (n == 0) n = 1;
                if (n > NOBJ) n = NOBJ;
                s = slabs_built;
                slabs_built++;
                for (int i = 0; i < n; i++) free_stk[s][i] = 5'(i);
                free_top[s] = n;
                live_cnt[s] = 0;
                slab_tag[s] = TAG_NONE;
                link_nxt[s] = NIL;
                link_prv[s] = NIL;
            end
            if (s >= NIL || free_top[s] == 0) begin
                g.status = ST_NO_SLAB;
            end else begin
                free_top[s]--;
                ob = int'(free_stk[s][free_top[s]]);
                live_cnt[s]++;
                g.status = ST_OK;
                g.first  = !seen_map[s][ob];
                seen_map[s][ob] = 1'b1;
                held_map[s][ob] = 1'b1;
                file_slab(s);
                g.slab = 4'(s);
                g.obj  = 5'(ob);
            end
        end
        grant_q.push_back(g);
    endtask

    // Check results, then record new requests and register writes
    always @(posedge i_clk) begin
        grant_t want;
        int     bad;
        if (!i_rst_n) begin
            cap_reg      = 6'd32;
            limit_reg    = 5'd16;
            partial_hd   = NIL;
            empty_hd     = NIL;
            slabs_built  = 0;
            o_fail_count <= 0;
            for (int i = 0; i < NSLAB; i++) begin
                free_top[i] = 0;
                held_map[i] = '0;
                seen_map[i] = '0;
                live_cnt[i] = 0;
                link_nxt[i] = NIL;
                link_prv[i] = NIL;
                slab_tag[i] = TAG_NONE;
            end
            grant_q.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (grant_q.size() == 0) begin
                    $error("result word with no request waiting: %h", i_rsp_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = grant_q.pop_front();
                    bad  = 0;
                    if (i_rsp_data[1:0] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_rsp_data[1:0]);
                        bad++;
                    end
                    if (i_rsp_data[5:2] !== want.slab) begin
                        $error("slab_out: expected %0d, got %0d", want.slab, i_rsp_data[5:2]);
                        bad++;
                    end
                    if (i_rsp_data[10:6] !== want.obj) begin
                        $error("object_out: expected %0d, got %0d", want.obj,
                               i_rsp_data[10:6]);
                        bad++;
                    end
                    if (i_rsp_data[11] !== want.first) begin
                        $error("first_use: expected %0d, got %0d", want.first, i_rsp_data[11]);
                        bad++;
                    end
                    o_fail_count <= o_fail_count + bad;
                end
            end
            if (i_req_valid && i_req_ready) serve_request(i_req_data);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_OBJ_IN_USE) cap_reg = i_cfg_data;
                else limit_reg = i_cfg_data[4:0];
            end
        end
        o_pending <= grant_q.size();
    end
endmodule

/* test/slab_object_allocator_top_tb.sv */
// ----------------------------------------------------------------------------
// slab_object_allocator_top_tb
// Drives allocate and release words through several register settings, with
// random request gaps and result stalls; the checker judges every result.
// ----------------------------------------------------------------------------
module slab_object_allocator_top_tb
    import soa_pkg::*;
();

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [5:0]  i_cfg_data;
    int          fail_count;
    int          pending;
    bit          hold_req;
    logic        sent_ops[$];
    logic [8:0]  held_pairs[$];

    slab_object_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    slab_object_allocator_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata),
        .i_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready),
        .i_rsp_data(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) < 75);
                @(posedge i_clk);
            end
        end
    end

    // Remember allocated pairs so most releases are well formed
    always @(posedge i_clk) begin
        logic op;
        if (i_rst_n && m_axis_tvalid && m_axis_tready && sent_ops.size() > 0) begin
            op = sent_ops.pop_front();
            if (op == OP_ALLOC && m_axis_tdata[1:0] == ST_OK)
                held_pairs.push_back({m_axis_tdata[10:6], m_axis_tdata[5:2]});
        end
    end

    // Offer one request word and hold it until accepted
    task automatic send_word(input logic op, input logic [3:0] sl, input logic [4:0] ob);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, ob, sl, op};
        sent_ops.push_back(op);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_release_held();
        int k;
        logic [8:0] pr;
        k  = $urandom_range(0, held_pairs.size() - 1);
        pr = held_pairs[k];
        held_pairs.delete(k);
        send_word(OP_RELEASE, pr[3:0], pr[8:4]);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [5:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain all results and let the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || sent_ops.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        logic [5:0] caps   [7] = '{6'd4, 6'd1, 6'd0, 6'd63, 6'd32, 6'd2, 6'd7};
        logic [4:0] limits [7] = '{5'd2, 5'd1, 5'd3, 5'd31, 5'd16, 5'd0, 5'd8};
        int alloc_pct;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        hold_req      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults, bad releases, extremes of fields
        send_word(OP_RELEASE, 4'd0, 5'd0);
        send_word(OP_ALLOC, 4'd15, 5'd31);
        send_word(OP_ALLOC, 4'd0, 5'd0);
        send_word(OP_RELEASE, 4'd0, 5'd31);
        send_word(OP_RELEASE, 4'd15, 5'd31);
        send_word(OP_RELEASE, 4'd0, 5'd30);
        send_word(OP_RELEASE, 4'd0, 5'd30);
        send_word(OP_ALLOC, 4'd0, 5'd0);
        send_word(OP_RELEASE, 4'd0, 5'd31);
        send_word(OP_RELEASE, 4'd0, 5'd30);
        send_word(OP_ALLOC, 4'd0, 5'd0);
        wait_idle();
        held_pairs.delete();
        held_pairs.push_back({5'd31, 4'd0});

        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_OBJ_IN_USE, caps[ph]);
            write_reg(REG_SLAB_LIMIT, limits[ph]);
            // Short directed burst: run into exhaustion on tight settings
            if (ph < 3) for (int i = 0; i < 6; i++) send_word(OP_ALLOC, 4'd0, 5'd0);
            if (ph == 3) hold_req = 1'b1;
            for (int i = 0; i < 110; i++) begin
                alloc_pct = ((i / 30) % 2 == 0) ? 70 : 30;
                if ($urandom_range(0, 99) < alloc_pct)
                    send_word(OP_ALLOC, 4'($urandom), 5'($urandom));
                else if (held_pairs.size() > 0 && $urandom_range(0, 99) < 85)
                    send_release_held();
                else
                    send_word(OP_RELEASE, 4'($urandom), 5'($urandom));
            end
            wait_idle();
        end

        if (fail_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
